/* rtl/line_raster_3d_assert.svh */
// ---------------------------------------------------------------------------
// line_raster_3d_assert: assertion macros
// Clocked property wrappers used by the checker file line_raster_3d_chk.
// ---------------------------------------------------------------------------
`ifndef LINE_RASTER_3D_ASSERT_SVH
`define LINE_RASTER_3D_ASSERT_SVH

// same-cycle implication
`define LR3D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_raster_3d: assertion failed");

// next-cycle implication
`define LR3D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_raster_3d: assertion failed");

`endif

/* rtl/lr3d_pkg.sv */
// ---------------------------------------------------------------------------
// lr3d_pkg
// Shared types and codes of the 3D line rasteriser.
// ---------------------------------------------------------------------------
package lr3d_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic       valid;
        logic       op;
        logic [2:0] neg;
    } cmd_ctl_t;

endpackage

/* rtl/lr3d_cmd_if.sv */
// ---------------------------------------------------------------------------
// lr3d_cmd_if
// Command channel: load or step word with line end points.
// ---------------------------------------------------------------------------
interface lr3d_cmd_if #(parameter int COORD_WIDTH = 16);

    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (
        output valid, op, start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );

    modport sink (
        input  valid, op, start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );

endinterface

/* rtl/lr3d_point_if.sv */
// ---------------------------------------------------------------------------
// lr3d_point_if
// Point channel: one rasterised point per word.
// ---------------------------------------------------------------------------
interface lr3d_point_if #(parameter int COORD_WIDTH = 16);

    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_point;

    modport source (
        output valid, point_x, point_y, point_z, last_point,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, last_point,
        output ready
    );

endinterface

/* rtl/lr3d_prep.sv */
// ---------------------------------------------------------------------------
// lr3d_prep
// Input register: captures a command word with per-axis delta magnitudes
// and signs.
// ---------------------------------------------------------------------------
module lr3d_prep #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    lr3d_cmd_if.sink               cmd,
    input  logic                   advance,
    output lr3d_pkg::cmd_ctl_t     ctl,
    output logic [COORD_WIDTH-1:0] start_x,
    output logic [COORD_WIDTH-1:0] start_y,
    output logic [COORD_WIDTH-1:0] start_z,
    output logic [COORD_WIDTH-1:0] mag_x,
    output logic [COORD_WIDTH-1:0] mag_y,
    output logic [COORD_WIDTH-1:0] mag_z
);
    import lr3d_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    function automatic logic [DW-1:0] delta(input logic [COORD_WIDTH-1:0] a,
                                            input logic [COORD_WIDTH-1:0] b);
        return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    endfunction

    function automatic logic [COORD_WIDTH-1:0] magnitude(input logic [DW-1:0] d);
        logic [DW-1:0] n;
        n = d[DW-1] ? (~d + 1'b1) : d;
        return n[COORD_WIDTH-1:0];
    endfunction

    logic [DW-1:0]          dx, dy, dz;
    cmd_ctl_t               ctl_reg, ctl_next;
    logic [COORD_WIDTH-1:0] start_x_reg, start_y_reg, start_z_reg;
    logic [COORD_WIDTH-1:0] mag_x_reg, mag_y_reg, mag_z_reg;
    logic                   accept;

    assign cmd.ready = !ctl_reg.valid || advance;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        dx = delta(cmd.end_x, cmd.start_x);
        dy = delta(cmd.end_y, cmd.start_y);
        dz = delta(cmd.end_z, cmd.start_z);
        ctl_next = ctl_reg;
        if (cmd.ready)
        begin
            ctl_next.valid = cmd.valid;
            ctl_next.op    = cmd.op;
            ctl_next.neg   = {dz[DW-1], dy[DW-1], dx[DW-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            start_x_reg <= cmd.start_x;
            start_y_reg <= cmd.start_y;
            start_z_reg <= cmd.start_z;
            mag_x_reg   <= magnitude(dx);
            mag_y_reg   <= magnitude(dy);
            mag_z_reg   <= magnitude(dz);
        end
    end

    assign ctl     = ctl_reg;
    assign start_x = start_x_reg;
    assign start_y = start_y_reg;
    assign start_z = start_z_reg;
    assign mag_x   = mag_x_reg;
    assign mag_y   = mag_y_reg;
    assign mag_z   = mag_z_reg;

endmodule

/* rtl/lr3d_step.sv */
// ---------------------------------------------------------------------------
// lr3d_step
// Line state, error terms and point output register.
// ---------------------------------------------------------------------------
module lr3d_step #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lr3d_pkg::cmd_ctl_t     ctl,
    input  logic [COORD_WIDTH-1:0] start_x,
    input  logic [COORD_WIDTH-1:0] start_y,
    input  logic [COORD_WIDTH-1:0] start_z,
    input  logic [COORD_WIDTH-1:0] mag_x,
    input  logic [COORD_WIDTH-1:0] mag_y,
    input  logic [COORD_WIDTH-1:0] mag_z,
    output logic                   advance,
    lr3d_point_if.source           point
);
    import lr3d_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int EW = COORD_WIDTH + 3;

    // {major, first minor, second minor}
    function automatic logic [3*W-1:0] pick(input axis_t a, input logic [W-1:0] x,
                                            input logic [W-1:0] y,
                                            input logic [W-1:0] z);
        logic [3*W-1:0] r;
        case (a)
            AXIS_Y:  r = {y, x, z};
            AXIS_Z:  r = {z, x, y};
            default: r = {x, y, z};
        endcase
        return r;
    endfunction

    function automatic logic [EW-1:0] twice(input logic [W-1:0] v);
        return {2'b00, v, 1'b0};
    endfunction

    function automatic logic [W-1:0] move(input logic [W-1:0] c, input logic neg);
        return neg ? (c - 1'b1) : (c + 1'b1);
    endfunction

    logic [W-1:0]         cur_x_reg, cur_y_reg, cur_z_reg;
    logic [W-1:0]         cur_x_next, cur_y_next, cur_z_next;
    logic [W-1:0]         mag_x_reg, mag_y_reg, mag_z_reg;
    logic [2:0]           neg_reg;
    axis_t                major_reg, major_next, major_ld;
    logic signed [EW-1:0] err1_reg, err1_next, err2_reg, err2_next;
    logic [W-1:0]         left_reg, left_next;
    logic                 point_valid_reg, point_valid_next;
    logic [W-1:0]         point_x_reg, point_y_reg, point_z_reg;
    logic                 last_reg;

    logic [3*W-1:0]       ld_pick, st_pick;
    logic [W-1:0]         ld_maj, ld_m1, ld_m2, st_maj, st_m1, st_m2;
    logic                 is_y, is_z, is_x, e1_pos, e2_pos;
    logic                 mv_x, mv_y, mv_z;
    logic [W-1:0]         nx, ny, nz;
    logic                 has_result, fire, fire_load, fire_step;

    assign has_result = (ctl.op == OP_STEP) && (left_reg != '0);
    assign advance    = !has_result || !point_valid_reg || point.ready;
    assign fire       = ctl.valid && advance;
    assign fire_load  = fire && (ctl.op == OP_LOAD);
    assign fire_step  = fire && has_result;

    always_comb
    begin
        if (mag_x >= mag_y && mag_x >= mag_z)
        begin
            major_ld = AXIS_X;
        end
        else if (mag_y >= mag_z)
        begin
            major_ld = AXIS_Y;
        end
        else
        begin
            major_ld = AXIS_Z;
        end
        ld_pick = pick(major_ld, mag_x, mag_y, mag_z);
        {ld_maj, ld_m1, ld_m2} = ld_pick;

        st_pick = pick(major_reg, mag_x_reg, mag_y_reg, mag_z_reg);
        {st_maj, st_m1, st_m2} = st_pick;

        is_y   = (major_reg == AXIS_Y);
        is_z   = (major_reg == AXIS_Z);
        is_x   = !is_y && !is_z;
        e1_pos = !err1_reg[EW-1] && (err1_reg != '0);
        e2_pos = !err2_reg[EW-1] && (err2_reg != '0);

        mv_x = is_x || e1_pos;
        mv_y = is_y || (is_x ? e1_pos : e2_pos);
        mv_z = is_z || e2_pos;

        nx = mv_x ? move(cur_x_reg, neg_reg[0]) : cur_x_reg;
        ny = mv_y ? move(cur_y_reg, neg_reg[1]) : cur_y_reg;
        nz = mv_z ? move(cur_z_reg, neg_reg[2]) : cur_z_reg;

        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cur_z_next = cur_z_reg;
        major_next = major_reg;
        err1_next  = err1_reg;
        err2_next  = err2_reg;
        left_next  = left_reg;

        if (fire_load)
        begin
            cur_x_next = start_x;
            cur_y_next = start_y;
            cur_z_next = start_z;
            major_next = major_ld;
            err1_next  = twice(ld_m1) - {3'b000, ld_maj};
            err2_next  = twice(ld_m2) - {3'b000, ld_maj};
            left_next  = ld_maj;
        end
        else if (fire_step)
        begin
            cur_x_next = nx;
            cur_y_next = ny;
            cur_z_next = nz;
            err1_next  = err1_reg + twice(st_m1) - (e1_pos ? twice(st_maj) : '0);
            err2_next  = err2_reg + twice(st_m2) - (e2_pos ? twice(st_maj) : '0);
            left_next  = left_reg - 1'b1;
        end

        if (fire_step)
        begin
            point_valid_next = 1'b1;
        end
        else if (point.ready)
        begin
            point_valid_next = 1'b0;
        end
        else
        begin
            point_valid_next = point_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            cur_z_reg       <= '0;
            major_reg       <= AXIS_X;
            err1_reg        <= '0;
            err2_reg        <= '0;
            left_reg        <= '0;
            point_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            cur_z_reg       <= cur_z_next;
            major_reg       <= major_next;
            err1_reg        <= err1_next;
            err2_reg        <= err2_next;
            left_reg        <= left_next;
            point_valid_reg <= point_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire_load)
        begin
            mag_x_reg <= mag_x;
            mag_y_reg <= mag_y;
            mag_z_reg <= mag_z;
            neg_reg   <= ctl.neg;
        end
        if (fire_step)
        begin
            point_x_reg <= nx;
            point_y_reg <= ny;
            point_z_reg <= nz;
            last_reg    <= (left_reg == W'(1));
        end
    end

    assign point.valid      = point_valid_reg;
    assign point.point_x    = point_x_reg;
    assign point.point_y    = point_y_reg;
    assign point.point_z    = point_z_reg;
    assign point.last_point = last_reg;

endmodule

/* rtl/line_raster_3d.sv */
// ---------------------------------------------------------------------------
// line_raster_3d
// 3D Bresenham line rasteriser with load and step command words.
// ---------------------------------------------------------------------------
// Takes one command word per clock and gives at most one point word per
// step, registered in the point register. A load word sets up a line from
// its start and end points; each following step word yields the next point
// along the line, the end point flagged by last_point. The start point is
// not emitted; a step on an empty or finished line yields nothing. The rate
// is one word per cycle, set by the single pass through the input register
// and the state and point register; cmd.ready falls only while a finished
// point waits in the point register and the word held next would make one.
module line_raster_3d #(
    parameter int COORD_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    lr3d_cmd_if.sink     cmd,
    lr3d_point_if.source point
);
    import lr3d_pkg::*;

    cmd_ctl_t               ctl;
    logic                   advance;
    logic [COORD_WIDTH-1:0] start_x, start_y, start_z;
    logic [COORD_WIDTH-1:0] mag_x, mag_y, mag_z;

    lr3d_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .advance (advance),
        .ctl     (ctl),
        .start_x (start_x),
        .start_y (start_y),
        .start_z (start_z),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .mag_z   (mag_z)
    );

    lr3d_step #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .start_x (start_x),
        .start_y (start_y),
        .start_z (start_z),
        .mag_x   (mag_x),
        .mag_y   (mag_y),
        .mag_z   (mag_z),
        .advance (advance),
        .point   (point)
    );

endmodule

/* rtl/line_raster_3d_chk.sv */
// ---------------------------------------------------------------------------
// line_raster_3d_chk
// Port-level checks on the rasteriser, bound to the top level.
// ---------------------------------------------------------------------------
`include "line_raster_3d_assert.svh"

module line_raster_3d_chk #(
    parameter int COORD_WIDTH = 16
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cmd_valid,
    input logic                   cmd_ready,
    input logic                   cmd_op,
    input logic                   point_valid,
    input logic                   point_ready,
    input logic [COORD_WIDTH-1:0] point_x,
    input logic [COORD_WIDTH-1:0] point_y,
    input logic [COORD_WIDTH-1:0] point_z,
    input logic                   point_last
);
    import lr3d_pkg::*;

    // hold a stalled point word
    `LR3D_ASSERT_NXT(a_point_hold, clk, rst_n, point_valid && !point_ready, point_valid)
    `LR3D_ASSERT_NXT(a_point_stable, clk, rst_n, point_valid && !point_ready, $stable(point_x) && $stable(point_y) && $stable(point_z) && $stable(point_last))

    // a load word never yields a point
    `LR3D_ASSERT_NXT(a_load_silent, clk, rst_n, (cmd_valid && cmd_ready && cmd_op == OP_LOAD) ##1 !point_valid, !point_valid)

    // with the point register free the command side must not stall
    `LR3D_ASSERT_IMP(a_no_stall, clk, rst_n, !point_valid, cmd_ready)

endmodule

bind line_raster_3d line_raster_3d_chk #(
    .COORD_WIDTH (COORD_WIDTH)
) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_op      (cmd.op),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .point_x     (point.point_x),
    .point_y     (point.point_y),
    .point_z     (point.point_z),
    .point_last  (point.last_point)
);
